[hdl/http_content_length_scanner_top_macros.svh]
// Assertion macros shared by the scanner modules.
// HCLS_ASSERT expects signals named clk and rst in the module that uses it; HCLS_ASSERT_RST expects clk.
`ifndef HTTP_CONTENT_LENGTH_SCANNER_TOP_MACROS_SVH
`define HTTP_CONTENT_LENGTH_SCANNER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define HCLS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("scanner assertion failed");
// Checked on every clock edge, reset included.
`define HCLS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("scanner reset assertion failed");
`else
`define HCLS_ASSERT(lbl, prop)
`define HCLS_ASSERT_RST(lbl, prop)
`endif

`endif

[hdl/hcls_pkg.sv]
package hcls_pkg;

  // Width of the parsed length.
  localparam int VALUE_BITS = 40;

  // Header name that is compared at the start of each line.
  localparam int NAME_LEN = 15;
  localparam int NAME_IDX_W = $clog2(NAME_LEN + 1);
  localparam logic [8*NAME_LEN-1:0] HDR_NAME = "Content-Length:";

  // Character codes used by the classifier.
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Depth of the queue between the classifier and the parser.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_SEEK,
    PH_MATCH,
    PH_SPACE,
    PH_SIGNED,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // Input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Result word.
  typedef struct packed {
    status_t               status;
    logic [VALUE_BITS-1:0] content_length;
  } out_word_t;

  // Classified byte as carried from the front to the back.
  typedef struct packed {
    logic [NAME_LEN-1:0] name_hit;
    logic                is_nl;
    logic                is_ws;
    logic                is_plus;
    logic                is_minus;
    logic                is_digit;
    logic [3:0]          digit_val;
    logic                last;
  } class_word_t;

endpackage

[hdl/http_content_length_scanner_top.sv]
// Channel  | Handshake            | Word
// ---------+----------------------+---------------------------------------
// input    | push / full          | in_data: data_byte, last_byte
// result   | empty / pop          | result: status, content_length
//
// One byte per clock, digit accumulate included, unless the parser holds; a
// result passes through the queue and then the output register.
// While a result waits unpopped the parser holds, and once the four-word
// queue between classifier and parser fills, full rises.
// Synchronous rst empties the queue and the output register and puts the
// parser in its seek-newline phase.
module http_content_length_scanner_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  hcls_pkg::in_word_t  in_data,
  output logic                empty,
  input  logic                pop,
  output hcls_pkg::out_word_t result
);

  logic                  q_wr;
  logic                  q_rd;
  logic                  q_valid;
  hcls_pkg::class_word_t q_in;
  hcls_pkg::class_word_t q_out;

  // Byte classifier.
  hcls_front u_front (
    .push    (push),
    .q_full  (full),
    .in_data (in_data),
    .q_wr    (q_wr),
    .q_word  (q_in)
  );

  // Queue of classified bytes.
  hcls_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_word (q_in),
    .rd      (q_rd),
    .full    (full),
    .valid   (q_valid),
    .rd_word (q_out)
  );

  // Header matcher and value parser.
  hcls_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_word  (q_out),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

[hdl/hcls_front.sv]
module hcls_front (
  input  logic                   push,
  input  logic                   q_full,
  input  hcls_pkg::in_word_t     in_data,
  output logic                   q_wr,
  output hcls_pkg::class_word_t  q_word
);

  logic [7:0] b;

  assign b = in_data.data_byte;
  assign q_wr = push && !q_full;

  // Compare the byte against every position of the header name at once,
  // and work out the character classes used by the value parser.
  always_comb begin
    for (int i = 0; i < hcls_pkg::NAME_LEN; i++) begin
      q_word.name_hit[i] =
        (b == hcls_pkg::HDR_NAME[8*(hcls_pkg::NAME_LEN-1-i) +: 8]);
    end
    q_word.is_nl    = (b == hcls_pkg::CH_NL);
    q_word.is_ws    = (b == hcls_pkg::CH_SPACE) || (b == hcls_pkg::CH_TAB) ||
                      (b == hcls_pkg::CH_NL) || (b == hcls_pkg::CH_VT) ||
                      (b == hcls_pkg::CH_FF) || (b == hcls_pkg::CH_CR);
    q_word.is_plus  = (b == hcls_pkg::CH_PLUS);
    q_word.is_minus = (b == hcls_pkg::CH_MINUS);
    q_word.is_digit = (b >= hcls_pkg::CH_ZERO) && (b <= hcls_pkg::CH_NINE);
    q_word.digit_val = b[3:0];
    q_word.last     = in_data.last_byte;
  end

endmodule

[hdl/hcls_queue.sv]
`include "http_content_length_scanner_top_macros.svh"

module hcls_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  hcls_pkg::class_word_t  wr_word,
  input  logic                   rd,
  output logic                   full,
  output logic                   valid,
  output hcls_pkg::class_word_t  rd_word
);

  hcls_pkg::class_word_t     mem [hcls_pkg::QDEPTH];
  logic [hcls_pkg::QPTR_W-1:0] wr_ptr;
  logic [hcls_pkg::QPTR_W-1:0] rd_ptr;
  logic [hcls_pkg::QPTR_W:0]   count;

  assign full    = (count == (hcls_pkg::QPTR_W+1)'(hcls_pkg::QDEPTH));
  assign valid   = (count != '0);
  assign rd_word = mem[rd_ptr];

  // Storage is written without reset; the count says what is valid.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `HCLS_ASSERT(a_q_no_overfill, count <= (hcls_pkg::QPTR_W+1)'(hcls_pkg::QDEPTH))
  `HCLS_ASSERT(a_q_no_underrun, !(rd && (count == '0)))
  `HCLS_ASSERT_RST(a_q_reset_empty, rst |=> (count == '0))

endmodule

[hdl/hcls_back.sv]
`include "http_content_length_scanner_top_macros.svh"

module hcls_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  hcls_pkg::class_word_t  q_word,
  output logic                   q_rd,
  input  logic                   pop,
  output logic                   empty,
  output hcls_pkg::out_word_t    result
);

  localparam int VB = hcls_pkg::VALUE_BITS;

  hcls_pkg::phase_t            phase;
  logic [hcls_pkg::NAME_IDX_W-1:0] match_index;
  logic [VB-1:0]               accumulated_value;
  logic                        negative_sign;
  logic                        digit_seen;
  logic                        res_valid;

  hcls_pkg::phase_t            phase_step;
  logic [hcls_pkg::NAME_IDX_W-1:0] mi_step;
  logic [VB-1:0]               acc_step;
  logic                        neg_step;
  logic                        seen_step;
  logic                        mid_emit;
  logic                        emit;
  hcls_pkg::status_t           emit_status;
  logic [VB-1:0]               emit_value;

  logic [VB+3:0]               acc_wide;
  logic [VB-1:0]               acc_digit;
  logic                        name_hit;

  assign empty = !res_valid;
  assign q_rd  = q_valid && (!res_valid || pop);

  // Saturating multiply by ten and add the digit.
  always_comb begin
    acc_wide = ({4'b0, accumulated_value} << 3) + ({4'b0, accumulated_value} << 1) +
               {{VB{1'b0}}, q_word.digit_val};
    acc_digit = (acc_wide[VB+3:VB] != 4'b0) ? {VB{1'b1}} : acc_wide[VB-1:0];
  end

  // Does the byte match the header name at the current position.
  always_comb begin
    name_hit = 1'b0;
    if (match_index < hcls_pkg::NAME_IDX_W'(hcls_pkg::NAME_LEN)) begin
      name_hit = q_word.name_hit[match_index];
    end
  end

  // Next state for one byte, before the last-byte handling.
  always_comb begin
    phase_step = phase;
    mi_step    = match_index;
    acc_step   = accumulated_value;
    neg_step   = negative_sign;
    seen_step  = digit_seen;
    mid_emit   = 1'b0;
    case (phase)
      hcls_pkg::PH_SEEK: begin
        if (q_word.is_nl) begin
          phase_step = hcls_pkg::PH_MATCH;
          mi_step    = '0;
        end
      end
      hcls_pkg::PH_MATCH: begin
        if (name_hit) begin
          mi_step = match_index + 1'b1;
          if (match_index == hcls_pkg::NAME_IDX_W'(hcls_pkg::NAME_LEN - 1)) begin
            phase_step = hcls_pkg::PH_SPACE;
          end
        end else if (q_word.is_nl) begin
          mi_step = '0;
        end else begin
          phase_step = hcls_pkg::PH_SEEK;
        end
      end
      hcls_pkg::PH_SPACE: begin
        if (q_word.is_ws) begin
          phase_step = phase;
        end else if (q_word.is_plus || q_word.is_minus) begin
          neg_step   = q_word.is_minus;
          phase_step = hcls_pkg::PH_SIGNED;
        end else if (q_word.is_digit) begin
          acc_step   = acc_digit;
          seen_step  = 1'b1;
          phase_step = hcls_pkg::PH_DIGITS;
        end else begin
          mid_emit   = 1'b1;
          phase_step = hcls_pkg::PH_DONE;
        end
      end
      hcls_pkg::PH_SIGNED: begin
        if (q_word.is_digit) begin
          acc_step   = acc_digit;
          seen_step  = 1'b1;
          phase_step = hcls_pkg::PH_DIGITS;
        end else begin
          mid_emit   = 1'b1;
          phase_step = hcls_pkg::PH_DONE;
        end
      end
      hcls_pkg::PH_DIGITS: begin
        if (q_word.is_digit) begin
          acc_step  = acc_digit;
          seen_step = 1'b1;
        end else begin
          mid_emit   = 1'b1;
          phase_step = hcls_pkg::PH_DONE;
        end
      end
      default: begin
        phase_step = phase;
      end
    endcase
  end

  // Result for this byte, if any.
  always_comb begin
    emit        = 1'b0;
    emit_status = hcls_pkg::ST_MALFORMED;
    emit_value  = '0;
    if (mid_emit || (q_word.last && (phase_step != hcls_pkg::PH_DONE))) begin
      emit = 1'b1;
      case (phase_step)
        hcls_pkg::PH_DIGITS,
        hcls_pkg::PH_DONE: begin
          // A value ended, by a non-digit or by the last byte; a non-digit before any digit makes it malformed.
          if (mid_emit && (phase != hcls_pkg::PH_DIGITS)) begin
            emit_status = hcls_pkg::ST_MALFORMED;
          end else if (!seen_step || neg_step || (acc_step == '0)) begin
            emit_status = hcls_pkg::ST_MALFORMED;
          end else begin
            emit_status = hcls_pkg::ST_FOUND;
            emit_value  = acc_step;
          end
        end
        hcls_pkg::PH_SPACE,
        hcls_pkg::PH_SIGNED: begin
          emit_status = hcls_pkg::ST_MALFORMED;
        end
        default: begin
          emit_status = hcls_pkg::ST_NOT_FOUND;
        end
      endcase
    end
  end

  // Parser state; the last byte of a message returns it to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= hcls_pkg::PH_SEEK;
      match_index       <= '0;
      accumulated_value <= '0;
      negative_sign     <= 1'b0;
      digit_seen        <= 1'b0;
    end else if (q_rd) begin
      if (q_word.last) begin
        phase             <= hcls_pkg::PH_SEEK;
        match_index       <= '0;
        accumulated_value <= '0;
        negative_sign     <= 1'b0;
        digit_seen        <= 1'b0;
      end else begin
        phase             <= phase_step;
        match_index       <= mi_step;
        accumulated_value <= acc_step;
        negative_sign     <= neg_step;
        digit_seen        <= seen_step;
      end
    end
  end

  // Output register: loads a new result when it is empty or as the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_rd && emit) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && emit) begin
      result.status         <= emit_status;
      result.content_length <= emit_value;
    end
  end

  `HCLS_ASSERT(a_seek_clean, (phase == hcls_pkg::PH_SEEK) |->
    ((accumulated_value == '0) && !negative_sign && !digit_seen))
  `HCLS_ASSERT(a_value_needs_digit, (accumulated_value != '0) |-> digit_seen)
  `HCLS_ASSERT(a_match_in_range, (phase == hcls_pkg::PH_MATCH) |->
    (match_index < hcls_pkg::NAME_IDX_W'(hcls_pkg::NAME_LEN)))

endmodule
